// ===== src/esae_pkg.sv =====
// ----------------------------------------------------------------------------
// esae_pkg
// types and constants shared by the encoder speed and angle estimator
// ----------------------------------------------------------------------------
package esae_pkg;

  localparam int NUM_W     = 38;
  localparam int DEN_W     = 48;
  localparam int CNT_W     = 6;
  localparam int DIV_STEPS = 38;

  localparam logic [15:0] ANGLE_SCALE = 16'd46080;
  localparam logic [22:0] SPEED_SCALE = 23'd5760000;
  localparam logic [16:0] ALPHA_ONE   = 17'd65536;
  localparam logic [15:0] PPR_RESET   = 16'd40817;
  localparam logic [16:0] ALPHA_RESET = 17'd655;

  localparam logic signed [23:0] SPD_MAX = 24'sh7fffff;
  localparam logic signed [23:0] SPD_MIN = 24'sh800000;

  localparam logic REG_PPR   = 1'b0;
  localparam logic REG_ALPHA = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_LOAD,
    ST_DIV,
    ST_SPD,
    ST_FPROD,
    ST_FSUM,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    PH_MOD,
    PH_ANG,
    PH_SPD
  } phase_t;

endpackage

// ===== src/encoder_speed_angle_estimator.sv =====
// ----------------------------------------------------------------------------
// encoder_speed_angle_estimator
// two-wheel angle, raw speed and low-pass speed from encoder snapshots
// ----------------------------------------------------------------------------
// one item at a time: a new input is taken only when idle
// each item runs the 38-step restoring divider
//   (one quotient bit per cycle, both wheels side by side) three times
// priming and unchanged-tick items finish in the cycle of their transfer
// reset: synchronous active-low, clears history, totals and filters
module encoder_speed_angle_estimator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [16:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        in_left_count,
  input  logic [15:0]        in_right_count,
  input  logic [31:0]        in_tick_ms,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        out_left_angle,
  output logic signed [23:0] out_left_speed,
  output logic signed [23:0] out_left_smoothed,
  output logic [15:0]        out_right_angle,
  output logic signed [23:0] out_right_speed,
  output logic signed [23:0] out_right_smoothed
);

  esae_pkg::state_t state_r, state_nxt;
  esae_pkg::phase_t phase_r;

  logic [15:0] ppr_r;
  logic [16:0] alpha_r;
  logic [15:0] prev_r [2];
  logic [31:0] prev_tick_r;
  logic [31:0] total_r [2];
  logic signed [23:0] filt_r [2];
  logic signed [15:0] diff_r [2];
  logic [31:0] dt_r;
  logic [esae_pkg::DEN_W-1:0] div_r;
  logic [esae_pkg::DEN_W-1:0] rem_r [2];
  logic [esae_pkg::NUM_W-1:0] nq_r [2];
  logic [esae_pkg::CNT_W-1:0] cnt_r;
  logic [15:0] angle_r [2];
  logic signed [23:0] speed_r [2];
  logic signed [41:0] proda_r [2];
  logic signed [41:0] prodb_r [2];
  logic out_valid_r;

  logic [15:0] ppr_eff;
  logic [16:0] alpha_eff;
  logic [16:0] beta;
  logic [15:0] cnt_in [2];
  logic signed [15:0] diff_in [2];
  logic [31:0] dt_in;
  logic in_xfer;
  logic [esae_pkg::DEN_W:0] rsh [2];
  logic ge [2];
  logic [esae_pkg::DEN_W-1:0] rem_step [2];
  logic [31:0] mag_tot [2];
  logic [16:0] mag_diff [2];
  logic signed [23:0] speed_sat [2];
  logic signed [42:0] fsum [2];
  logic signed [26:0] fshift [2];
  logic signed [23:0] fsat [2];

  assign ppr_eff   = (ppr_r == 16'd0) ? 16'd1 : ppr_r;
  assign alpha_eff = (alpha_r > esae_pkg::ALPHA_ONE) ? esae_pkg::ALPHA_ONE : alpha_r;
  assign beta      = esae_pkg::ALPHA_ONE - alpha_eff;
  assign cnt_in[0] = in_left_count;
  assign cnt_in[1] = in_right_count;
  assign dt_in     = in_tick_ms - prev_tick_r;
  assign in_xfer   = in_valid && in_ready;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      diff_in[l]   = $signed(cnt_in[l] - prev_r[l]);
      rsh[l]       = {rem_r[l], nq_r[l][esae_pkg::NUM_W-1]};
      ge[l]        = rsh[l] >= {1'b0, div_r};
      rem_step[l]  = ge[l] ? esae_pkg::DEN_W'(rsh[l] - {1'b0, div_r})
                           : rsh[l][esae_pkg::DEN_W-1:0];
      mag_tot[l]   = total_r[l][31] ? (32'd0 - total_r[l]) : total_r[l];
      mag_diff[l]  = diff_r[l][15] ? (17'd0 - 17'($signed(diff_r[l])))
                                   : 17'($signed(diff_r[l]));
      if (diff_r[l][15]) begin
        if (nq_r[l] > esae_pkg::NUM_W'(24'h800000)) speed_sat[l] = esae_pkg::SPD_MIN;
        else speed_sat[l] = 24'sd0 - $signed(nq_r[l][23:0]);
      end else begin
        if (nq_r[l] > esae_pkg::NUM_W'(24'h7fffff)) speed_sat[l] = esae_pkg::SPD_MAX;
        else speed_sat[l] = $signed(nq_r[l][23:0]);
      end
      fsum[l]   = 43'(proda_r[l]) + 43'(prodb_r[l]) + 43'sd32768;
      fshift[l] = fsum[l][42:16];
      if (fshift[l] > 27'(esae_pkg::SPD_MAX)) fsat[l] = esae_pkg::SPD_MAX;
      else if (fshift[l] < 27'(esae_pkg::SPD_MIN)) fsat[l] = esae_pkg::SPD_MIN;
      else fsat[l] = fshift[l][23:0];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      esae_pkg::ST_IDLE: begin
        if (in_xfer && prev_tick_r != 32'd0 && dt_in != 32'd0) state_nxt = esae_pkg::ST_MUL;
      end
      esae_pkg::ST_MUL:   state_nxt = esae_pkg::ST_LOAD;
      esae_pkg::ST_LOAD:  state_nxt = esae_pkg::ST_DIV;
      esae_pkg::ST_DIV: begin
        if (cnt_r == esae_pkg::CNT_W'(esae_pkg::DIV_STEPS - 1)) begin
          if (phase_r == esae_pkg::PH_SPD) state_nxt = esae_pkg::ST_SPD;
          else state_nxt = esae_pkg::ST_LOAD;
        end
      end
      esae_pkg::ST_SPD:   state_nxt = esae_pkg::ST_FPROD;
      esae_pkg::ST_FPROD: state_nxt = esae_pkg::ST_FSUM;
      esae_pkg::ST_FSUM:  state_nxt = esae_pkg::ST_DONE;
      esae_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) state_nxt = esae_pkg::ST_IDLE;
      end
      default: state_nxt = esae_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready  = (state_r == esae_pkg::ST_IDLE);
    out_valid = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= esae_pkg::ST_IDLE;
      phase_r     <= esae_pkg::PH_MOD;
      ppr_r       <= esae_pkg::PPR_RESET;
      alpha_r     <= esae_pkg::ALPHA_RESET;
      prev_tick_r <= 32'd0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      for (int l = 0; l < 2; l++) begin
        prev_r[l]  <= 16'd0;
        total_r[l] <= 32'd0;
        filt_r[l]  <= 24'sd0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        if (cfg_index == esae_pkg::REG_PPR) ppr_r <= cfg_data[15:0];
        else alpha_r <= cfg_data;
      end
      if (state_r == esae_pkg::ST_DONE && (!out_valid_r || out_ready)) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      case (state_r)
        esae_pkg::ST_IDLE: begin
          if (in_xfer) begin
            prev_tick_r <= in_tick_ms;
            dt_r        <= dt_in;
            for (int l = 0; l < 2; l++) begin
              prev_r[l] <= cnt_in[l];
              diff_r[l] <= diff_in[l];
              if (prev_tick_r != 32'd0) total_r[l] <= total_r[l] + 32'($signed(diff_in[l]));
            end
          end
        end
        esae_pkg::ST_MUL: begin
          div_r   <= esae_pkg::DEN_W'(ppr_eff);
          phase_r <= esae_pkg::PH_MOD;
          for (int l = 0; l < 2; l++) nq_r[l] <= esae_pkg::NUM_W'(mag_tot[l]);
        end
        esae_pkg::ST_LOAD: begin
          cnt_r <= '0;
          if (phase_r == esae_pkg::PH_MOD) begin
            div_r <= esae_pkg::DEN_W'(ppr_eff);
            for (int l = 0; l < 2; l++) begin
              nq_r[l]  <= esae_pkg::NUM_W'(mag_tot[l]);
              rem_r[l] <= '0;
            end
          end else if (phase_r == esae_pkg::PH_ANG) begin
            div_r <= esae_pkg::DEN_W'(ppr_eff);
            for (int l = 0; l < 2; l++) begin
              nq_r[l]  <= esae_pkg::NUM_W'(32'(rem_r[l][15:0]) * 32'(esae_pkg::ANGLE_SCALE));
              rem_r[l] <= '0;
            end
          end else begin
            div_r <= esae_pkg::DEN_W'(ppr_eff) * esae_pkg::DEN_W'(dt_r);
            for (int l = 0; l < 2; l++) begin
              angle_r[l] <= nq_r[l][15:0];
              nq_r[l]    <= esae_pkg::NUM_W'(esae_pkg::NUM_W'(mag_diff[l]) *
                                             esae_pkg::NUM_W'(esae_pkg::SPEED_SCALE));
              rem_r[l]   <= '0;
            end
          end
        end
        esae_pkg::ST_DIV: begin
          cnt_r <= cnt_r + 1'b1;
          for (int l = 0; l < 2; l++) begin
            rem_r[l] <= rem_step[l];
            nq_r[l]  <= {nq_r[l][esae_pkg::NUM_W-2:0], ge[l]};
          end
          if (cnt_r == esae_pkg::CNT_W'(esae_pkg::DIV_STEPS - 1)) begin
            if (phase_r == esae_pkg::PH_MOD) phase_r <= esae_pkg::PH_ANG;
            else if (phase_r == esae_pkg::PH_ANG) phase_r <= esae_pkg::PH_SPD;
          end
        end
        esae_pkg::ST_SPD: begin
          for (int l = 0; l < 2; l++) speed_r[l] <= speed_sat[l];
        end
        esae_pkg::ST_FPROD: begin
          for (int l = 0; l < 2; l++) begin
            proda_r[l] <= $signed({25'd0, alpha_eff}) * 42'(speed_r[l]);
            prodb_r[l] <= $signed({25'd0, beta}) * 42'(filt_r[l]);
          end
        end
        esae_pkg::ST_FSUM: begin
          for (int l = 0; l < 2; l++) filt_r[l] <= fsat[l];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == esae_pkg::ST_DONE && (!out_valid_r || out_ready)) begin
      out_left_angle     <= angle_r[0];
      out_left_speed     <= speed_r[0];
      out_left_smoothed  <= filt_r[0];
      out_right_angle    <= angle_r[1];
      out_right_speed    <= speed_r[1];
      out_right_smoothed <= filt_r[1];
    end
  end

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// encoder speed and angle estimator testbench
// drives encoder snapshots with random gaps and output stalls, predicts the
// angle, raw speed and filtered speed of both wheels, and checks each result
// ----------------------------------------------------------------------------
module testbench;

  typedef struct packed {
    logic [15:0] left_angle;
    logic [23:0] left_speed;
    logic [23:0] left_smoothed;
    logic [15:0] right_angle;
    logic [23:0] right_speed;
    logic [23:0] right_smoothed;
  } wheel_result_t;

  localparam int SETTLE_CYCLES = 160;
  localparam int STALL_LIMIT   = 3000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = esae_pkg::REG_PPR;
  logic [16:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] in_left_count = '0;
  logic [15:0] in_right_count = '0;
  logic [31:0] in_tick_ms = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_left_angle;
  logic signed [23:0] out_left_speed;
  logic signed [23:0] out_left_smoothed;
  logic [15:0] out_right_angle;
  logic signed [23:0] out_right_speed;
  logic signed [23:0] out_right_smoothed;

  wheel_result_t pending_results[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit no_idle = 1'b0;

  // predictor state
  logic [15:0] est_ppr;
  logic [16:0] est_alpha;
  logic [15:0] last_left;
  logic [15:0] last_right;
  logic [31:0] last_tick;
  logic [31:0] sum_left;
  logic [31:0] sum_right;
  longint      lp_left;
  longint      lp_right;

  // stimulus history
  logic [15:0] gen_left;
  logic [15:0] gen_right;
  logic [31:0] gen_tick;

  encoder_speed_angle_estimator dut (.*);

  always #1 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic longint eff_ppr();
    return (est_ppr == 16'd0) ? 64'd1 : longint'(est_ppr);
  endfunction

  function automatic int count_delta(logic [15:0] now, logic [15:0] was);
    logic [15:0] d;
    d = now - was;
    return int'($signed(d));
  endfunction

  function automatic logic [15:0] shaft_angle(logic [31:0] total);
    logic [31:0] mag;
    longint r;
    mag = total[31] ? (32'd0 - total) : total;
    r = longint'(mag) % eff_ppr();
    return 16'((r * 46080) / eff_ppr());
  endfunction

  function automatic longint clamp_speed(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  function automatic longint raw_speed(int delta, logic [31:0] dt);
    longint num;
    longint den;
    num = longint'(delta) * 5760000;
    den = eff_ppr() * longint'(dt);
    return clamp_speed(num / den);
  endfunction

  function automatic longint smooth_speed(longint filt, longint spd);
    longint a;
    longint q;
    a = (est_alpha > 17'd65536) ? 64'd65536 : longint'(est_alpha);
    q = a * spd + (65536 - a) * filt + 32768;
    if (q >= 0) return clamp_speed(q / 65536);
    return clamp_speed(-((-q + 65535) / 65536));
  endfunction

  task automatic predict_item(logic [15:0] lc, logic [15:0] rc, logic [31:0] tick);
    int dl;
    int dr;
    logic [31:0] dt;
    longint ls;
    longint rs;
    wheel_result_t res;
    if (last_tick == 32'd0) begin
      last_tick = tick;
      last_left = lc;
      last_right = rc;
      return;
    end
    dl = count_delta(lc, last_left);
    dr = count_delta(rc, last_right);
    sum_left = sum_left + 32'(dl);
    sum_right = sum_right + 32'(dr);
    dt = tick - last_tick;
    if (dt != 32'd0) begin
      ls = raw_speed(dl, dt);
      rs = raw_speed(dr, dt);
      lp_left = smooth_speed(lp_left, ls);
      lp_right = smooth_speed(lp_right, rs);
      res.left_angle = shaft_angle(sum_left);
      res.left_speed = 24'(ls);
      res.left_smoothed = 24'(lp_left);
      res.right_angle = shaft_angle(sum_right);
      res.right_speed = 24'(rs);
      res.right_smoothed = 24'(lp_right);
      pending_results.push_back(res);
    end
    last_left = lc;
    last_right = rc;
    last_tick = tick;
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic send_item(logic [15:0] lc, logic [15:0] rc, logic [31:0] tick);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_left_count = lc;
    in_right_count = rc;
    in_tick_ms = tick;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_item(lc, rc, tick);
    gen_left = lc;
    gen_right = rc;
    gen_tick = tick;
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [16:0] data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == esae_pkg::REG_PPR) est_ppr = data[15:0];
    else est_alpha = data;
  endtask

  task automatic set_config(logic [15:0] ppr, logic [16:0] alpha);
    settle();
    write_reg(esae_pkg::REG_PPR, {1'b0, ppr});
    write_reg(esae_pkg::REG_ALPHA, alpha);
  endtask

  task automatic test_priming();
    send_item(16'hffff, 16'h0000, 32'd0);
    send_item(16'h1234, 16'hfedc, 32'd0);
    send_item(16'h0000, 16'hffff, 32'hffff_fff0);
    send_item(16'h0000, 16'hffff, 32'hffff_fff0);
    send_item(16'h7fff, 16'h7fff, 32'hffff_fffa);
    send_item(16'hffff, 16'hffff, 32'h0000_0005);
    send_item(16'h7fff, 16'h8000, 32'h0000_0006);
    send_item(16'h7fff, 16'h8000, 32'hffff_ffff);
  endtask

  task automatic test_extreme_config();
    set_config(16'd1, 17'd65536);
    send_item(gen_left + 16'd32767, gen_right - 16'd32768, gen_tick + 32'd1);
    send_item(gen_left - 16'd3, gen_right + 16'd9, gen_tick + 32'hffff_fff0);
    set_config(16'd0, 17'h1ffff);
    send_item(gen_left + 16'd100, gen_right - 16'd100, gen_tick + 32'd2);
    send_item(gen_left, gen_right, gen_tick + 32'd1);
    set_config(16'hffff, 17'd0);
    send_item(gen_left + 16'd32767, gen_right - 16'd32767, gen_tick + 32'd1);
    send_item(gen_left + 16'd1, gen_right - 16'd1, gen_tick + 32'd7);
    set_config(16'd1, 17'd65535);
    send_item(gen_left - 16'd32768, gen_right + 16'd32767, gen_tick + 32'd1);
    send_item(gen_left - 16'd32768, gen_right + 16'd32767, gen_tick + 32'd3);
  endtask

  task automatic test_random(int count, logic [15:0] ppr, logic [16:0] alpha);
    int r;
    logic [15:0] lc;
    logic [15:0] rc;
    logic [31:0] tick;
    set_config(ppr, alpha);
    no_idle = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 85) begin
        lc = gen_left + 16'($signed($urandom_range(0, 400)) - 200);
        rc = gen_right + 16'($signed($urandom_range(0, 400)) - 200);
      end else begin
        lc = 16'($urandom);
        rc = 16'($urandom);
      end
      r = $urandom_range(0, 99);
      if (r < 80) tick = gen_tick + $urandom_range(1, 50);
      else if (r < 90) tick = gen_tick;
      else if (r < 98) tick = $urandom;
      else tick = 32'd0;
      send_item(lc, rc, tick);
      if ($urandom_range(0, 49) == 0) no_idle = ~no_idle;
    end
    no_idle = 1'b0;
  endtask

  always @(negedge clk) begin
    if (no_idle) out_ready <= 1'b1;
    else if ($urandom_range(0, 99) < 3) out_ready <= 1'b0;
    else if (!out_ready && $urandom_range(0, 99) < 10) out_ready <= 1'b1;
    else if (out_ready && $urandom_range(0, 99) < 20) out_ready <= 1'b0;
    else out_ready <= out_ready | ($urandom_range(0, 1) == 1);
  end

  always @(posedge clk) begin
    wheel_result_t want;
    wheel_result_t got;
    if (rst_n && out_valid && out_ready) begin
      got = {out_left_angle, out_left_speed, out_left_smoothed,
             out_right_angle, out_right_speed, out_right_smoothed};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer: %h", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h actual %h", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    est_ppr = esae_pkg::PPR_RESET;
    est_alpha = esae_pkg::ALPHA_RESET;
    last_left = '0;
    last_right = '0;
    last_tick = '0;
    sum_left = '0;
    sum_right = '0;
    lp_left = 0;
    lp_right = 0;
    gen_left = '0;
    gen_right = '0;
    gen_tick = '0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    test_priming();
    test_extreme_config();
    test_random(190, esae_pkg::PPR_RESET, esae_pkg::ALPHA_RESET);
    test_random(190, 16'd1, 17'd65536);
    test_random(190, 16'hffff, 17'd0);
    test_random(190, 16'(1 + $urandom_range(0, 99)), 17'($urandom_range(0, 131071)));
    test_random(190, 16'($urandom), 17'($urandom_range(0, 65536)));
    test_random(190, 16'd0, 17'($urandom));
    settle();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== encoder_speed_angle_estimator.f =====
src/esae_pkg.sv
src/encoder_speed_angle_estimator.sv
dv/testbench.sv
